@@ hw/rtl/ntts_pkg.sv @@
package ntts_pkg;

    localparam int NUM_STATIONS_DEF  = 4;
    localparam int NUM_STREAMS_DEF   = 2;
    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int SEC_W     = 32;
    localparam int NANO_W    = 30;
    localparam int WORD_W    = SEC_W + NANO_W;
    localparam int T_W       = 62;
    localparam int STA_W     = 2;
    localparam int STRM_W    = 1;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 10;

    localparam logic [NANO_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [STA_W-1:0]  station_sel;
        logic [STRM_W-1:0] stream_sel;
        logic              restart;
        logic [SEC_W-1:0]  entry_seconds;
        logic [NANO_W-1:0] entry_nanos;
        logic [SEC_W-1:0]  query_seconds;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] found_index;
        logic [SEC_W-1:0]     found_seconds;
        logic [NANO_W-1:0]    found_nanos;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_LO,
        S_CHK_LO,
        S_CHK_HI,
        S_PROBE,
        S_T_LO_MUL,
        S_T_LO_ADD,
        S_T_HI_MUL,
        S_T_HI_ADD,
        S_T_DIFF,
        S_T_PICK
    } t_state;

    typedef enum logic [1:0] {
        RD_LO,
        RD_HI,
        RD_MID
    } t_rd_sel;

    typedef enum logic [2:0] {
        E_LOAD,
        E_FULL,
        E_EMPTY,
        E_RD_LO,
        E_RD_HI,
        E_PICK
    } t_emit;

    typedef struct packed {
        logic    capture;
        logic    load_write;
        logic    init_search;
        t_rd_sel rd_sel;
        logic    take_lo;
        logic    take_hi;
        logic    capture_mid;
        logic    probe_update;
        logic    mul_lo;
        logic    mul_hi;
        logic    add_lo;
        logic    add_hi;
        logic    diff0;
        logic    diff1;
        logic    emit;
        t_emit   emit_src;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic valid;
        logic len_zero;
        logic full;
        logic rd_gt;
        logic rd_ge;
        logic more;
    } t_stat;

    // Exact compare of seconds*1e9 + nanos against qsec*1e9 without a multiplier.
    // The nanosecond part stays below two seconds, so only the same second and
    // the second just before the query can come close.
    function automatic logic word_gt(input logic [WORD_W-1:0] word,
                                     input logic [SEC_W-1:0]  qsec);
        logic [SEC_W-1:0]  sec;
        logic [NANO_W-1:0] nano;
        sec  = word[WORD_W-1:NANO_W];
        nano = word[NANO_W-1:0];
        return (sec > qsec) || ((sec == qsec) && (nano != '0)) ||
               ((qsec != '0) && (sec == qsec - SEC_W'(1)) && (nano > NS_PER_SEC));
    endfunction

    function automatic logic word_ge(input logic [WORD_W-1:0] word,
                                     input logic [SEC_W-1:0]  qsec);
        logic [SEC_W-1:0]  sec;
        logic [NANO_W-1:0] nano;
        sec  = word[WORD_W-1:NANO_W];
        nano = word[NANO_W-1:0];
        return (sec >= qsec) ||
               ((qsec != '0) && (sec == qsec - SEC_W'(1)) && (nano >= NS_PER_SEC));
    endfunction

    function automatic logic [T_W-1:0] abs_diff(input logic [T_W-1:0] a,
                                                input logic [T_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hw/rtl/ntts_ctrl.sv @@
module ntts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ntts_pkg::t_stat i_stat,
    output ntts_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import ntts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel   = RD_LO;
        o_cmd.emit_src = E_FULL;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (i_stat.is_query) begin
                    if (i_stat.len_zero) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = E_EMPTY;
                    end else begin
                        o_cmd.init_search = 1'b1;
                        n_state = S_RD_LO;
                    end
                end else if (!i_stat.valid || i_stat.full) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = E_FULL;
                end else begin
                    o_cmd.load_write = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_src   = E_LOAD;
                end
            end
            S_RD_LO: begin
                o_cmd.rd_sel = RD_LO;
                n_state = S_CHK_LO;
            end
            S_CHK_LO: begin
                o_cmd.take_lo = 1'b1;
                if (i_stat.rd_gt) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = E_RD_LO;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_HI;
                    n_state = S_CHK_HI;
                end
            end
            S_CHK_HI: begin
                o_cmd.take_hi = 1'b1;
                if (!i_stat.rd_ge) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = E_RD_HI;
                    n_state = S_IDLE;
                end else if (i_stat.more) begin
                    o_cmd.rd_sel      = RD_MID;
                    o_cmd.capture_mid = 1'b1;
                    n_state = S_PROBE;
                end else begin
                    n_state = S_T_LO_MUL;
                end
            end
            S_PROBE: begin
                // The bracket update and the next probe address resolve in the same cycle.
                o_cmd.probe_update = 1'b1;
                if (i_stat.more) begin
                    o_cmd.rd_sel      = RD_MID;
                    o_cmd.capture_mid = 1'b1;
                end else begin
                    n_state = S_T_LO_MUL;
                end
            end
            S_T_LO_MUL: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_T_LO_ADD;
            end
            S_T_LO_ADD: begin
                o_cmd.add_lo = 1'b1;
                n_state = S_T_HI_MUL;
            end
            S_T_HI_MUL: begin
                o_cmd.mul_hi = 1'b1;
                o_cmd.diff0  = 1'b1;
                n_state = S_T_HI_ADD;
            end
            S_T_HI_ADD: begin
                o_cmd.add_hi = 1'b1;
                n_state = S_T_DIFF;
            end
            S_T_DIFF: begin
                o_cmd.diff1 = 1'b1;
                n_state = S_T_PICK;
            end
            S_T_PICK: begin
                o_cmd.emit     = 1'b1;
                o_cmd.emit_src = E_PICK;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not make the block busy");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a result");
`endif

endmodule

@@ hw/rtl/ntts_dp.sv @@
module ntts_dp #(
    parameter int NUM_STATIONS  = ntts_pkg::NUM_STATIONS_DEF,
    parameter int NUM_STREAMS   = ntts_pkg::NUM_STREAMS_DEF,
    parameter int TABLE_ENTRIES = ntts_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntts_pkg::t_item   i_item,
    input  ntts_pkg::t_cmd    i_cmd,
    output ntts_pkg::t_stat   o_stat,
    output logic              o_done,
    output ntts_pkg::t_result o_result
);
    import ntts_pkg::*;

    localparam int NTAB   = NUM_STATIONS * NUM_STREAMS;
    localparam int DEPTH  = NTAB * TABLE_ENTRIES;
    localparam int TAB_W  = (NTAB > 1) ? $clog2(NTAB) : 1;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int LEN_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    t_item             r_item;
    logic [T_W-1:0]    r_q;
    logic              r_valid;
    logic [TAB_W-1:0]  r_tab;
    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_len [NTAB];
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_hi;
    logic [IDX_W-1:0]  r_mid;
    logic [WORD_W-1:0] r_lo_word;
    logic [WORD_W-1:0] r_hi_word;
    logic [WORD_W-1:0] r_rdata;
    logic [T_W-1:0]    r_prod;
    logic [T_W-1:0]    r_t;
    logic [T_W-1:0]    r_d0;
    logic [T_W-1:0]    r_d1;
    logic              r_done;
    t_result           r_result;

    logic              cap_valid;
    logic [TAB_W-1:0]  cap_tab;
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  n_q;
    logic              full;
    logic              rd_gt;
    logic              rd_ge;
    logic [IDX_W-1:0]  n_lo;
    logic [IDX_W-1:0]  n_hi;
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid_next;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] mul_word;
    logic [WORD_W-1:0] add_word;
    logic              pick_lo;
    t_result           n_result;

    assign cap_valid = (int'(i_item.station_sel) < NUM_STATIONS) &&
                       (int'(i_item.stream_sel) < NUM_STREAMS);
    assign cap_tab   = cap_valid ? TAB_W'(int'(i_item.station_sel) * NUM_STREAMS +
                                          int'(i_item.stream_sel)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item  <= i_item;
            r_valid <= cap_valid;
            r_tab   <= cap_tab;
            r_base  <= ADDR_W'(int'(cap_tab) * TABLE_ENTRIES);
            r_q     <= T_W'(i_item.query_seconds) * T_W'(NS_PER_SEC);
        end
    end

    assign len_cur = r_len[r_tab];
    assign len_eff = r_item.restart ? '0 : len_cur;
    assign full    = (len_eff >= LEN_W'(TABLE_ENTRIES));
    assign n_q     = r_valid ? len_cur : '0;

    assign rd_gt = word_gt(r_rdata, r_item.query_seconds);
    assign rd_ge = word_ge(r_rdata, r_item.query_seconds);

    assign o_stat.is_query = (r_item.operation == OP_QUERY);
    assign o_stat.valid    = r_valid;
    assign o_stat.len_zero = (n_q == '0);
    assign o_stat.full     = full;
    assign o_stat.rd_gt    = rd_gt;
    assign o_stat.rd_ge    = rd_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NTAB; k++) begin
                r_len[k] <= '0;
            end
        end else if (i_cmd.load_write) begin
            r_len[r_tab] <= len_eff + LEN_W'(1);
        end
    end

    // Bisection bracket; a probe that hits the query exactly moves both ends.
    assign n_lo     = (i_cmd.probe_update && !rd_gt) ? r_mid : r_lo;
    assign n_hi     = (i_cmd.probe_update && rd_ge) ? r_mid : r_hi;
    assign mid_sum  = {1'b0, n_lo} + {1'b0, n_hi};
    assign mid_next = mid_sum[IDX_W:1];
    assign o_stat.more = ((n_hi - n_lo) > IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_search) begin
            r_lo <= '0;
            r_hi <= IDX_W'(n_q - LEN_W'(1));
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd.capture_mid) begin
            r_mid <= mid_next;
        end
        if (i_cmd.take_lo || (i_cmd.probe_update && !rd_gt)) begin
            r_lo_word <= r_rdata;
        end
        if (i_cmd.take_hi || (i_cmd.probe_update && rd_ge)) begin
            r_hi_word <= r_rdata;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HI:   rd_idx = r_hi;
            RD_MID:  rd_idx = mid_next;
            default: rd_idx = r_lo;
        endcase
    end

    assign raddr = r_base + ADDR_W'(rd_idx);
    assign waddr = r_base + ADDR_W'(len_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            mem[waddr] <= {r_item.entry_seconds, r_item.entry_nanos};
        end
        r_rdata <= mem[raddr];
    end

    // Final distance check: one multiply, then one add, then one subtract for each bracketing entry.
    assign mul_word = i_cmd.mul_hi ? r_hi_word : r_lo_word;
    assign add_word = i_cmd.add_hi ? r_hi_word : r_lo_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_prod <= T_W'(mul_word[WORD_W-1:NANO_W]) * T_W'(NS_PER_SEC);
        end
        if (i_cmd.add_lo || i_cmd.add_hi) begin
            r_t <= r_prod + T_W'(add_word[NANO_W-1:0]);
        end
        if (i_cmd.diff0) begin
            r_d0 <= abs_diff(r_t, r_q);
        end
        if (i_cmd.diff1) begin
            r_d1 <= abs_diff(r_t, r_q);
        end
    end

    assign pick_lo = (r_d0 < r_d1);

    always_comb begin
        n_result = '0;
        unique case (i_cmd.emit_src)
            E_LOAD: begin
                n_result.status        = ST_OK;
                n_result.found_index   = IDX_OUT_W'(len_eff);
                n_result.found_seconds = r_item.entry_seconds;
                n_result.found_nanos   = r_item.entry_nanos;
            end
            E_FULL: begin
                n_result.status = ST_FULL;
            end
            E_EMPTY: begin
                n_result.status = ST_EMPTY;
            end
            E_RD_LO: begin
                n_result.status        = ST_OK;
                n_result.found_index   = IDX_OUT_W'(r_lo);
                n_result.found_seconds = r_rdata[WORD_W-1:NANO_W];
                n_result.found_nanos   = r_rdata[NANO_W-1:0];
            end
            E_RD_HI: begin
                n_result.status        = ST_OK;
                n_result.found_index   = IDX_OUT_W'(r_hi);
                n_result.found_seconds = r_rdata[WORD_W-1:NANO_W];
                n_result.found_nanos   = r_rdata[NANO_W-1:0];
            end
            E_PICK: begin
                n_result.status = ST_OK;
                if (pick_lo) begin
                    n_result.found_index   = IDX_OUT_W'(r_lo);
                    n_result.found_seconds = r_lo_word[WORD_W-1:NANO_W];
                    n_result.found_nanos   = r_lo_word[NANO_W-1:0];
                end else begin
                    n_result.found_index   = IDX_OUT_W'(r_hi);
                    n_result.found_seconds = r_hi_word[WORD_W-1:NANO_W];
                    n_result.found_nanos   = r_hi_word[NANO_W-1:0];
                end
            end
            default: begin
                n_result.status = ST_FULL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_probe_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe_update |-> ((r_lo < r_mid) && (r_mid < r_hi)))
        else $error("probe index is outside the search bracket");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_write |-> (r_valid && !full))
        else $error("table write without room in a valid table");
`endif

endmodule

@@ hw/rtl/nearest_time_table_search_top.sv @@
// Nearest-time table search. Each item is taken when start is high while busy is low,
// and gives exactly one result beat: o_done is high for one cycle with o_result, and
// the receiver cannot hold it off, so it must take every beat as it comes. A load
// appends one timestamp to the selected station/stream table (restart empties it
// first) and answers without a table read; a query on an empty table does so too.
// A query before the first entry answers once that entry is read, and one after the last
// entry once the last entry is read. Any other query bisects the bracket between them and
// then picks the nearer bracketing entry. The probes are paced by the single read port of
// the table memory, one probe per cycle. The epoch is scaled to nanoseconds by a 32x30
// multiplier when the item is taken. The final nearest-entry choice uses a second 32x30
// multiplier, once for each bracketing entry. busy stays high until the result beat is
// issued, and a new item can be taken in the cycle that beat is shown. Table contents
// are not cleared at reset; only the per-table lengths are, so no clearing pass runs.
module nearest_time_table_search_top #(
    parameter int NUM_STATIONS  = ntts_pkg::NUM_STATIONS_DEF,
    parameter int NUM_STREAMS   = ntts_pkg::NUM_STREAMS_DEF,
    parameter int TABLE_ENTRIES = ntts_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ntts_pkg::t_item   i_item,
    output logic              o_done,
    output ntts_pkg::t_result o_result
);
    import ntts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ntts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ntts_dp #(
        .NUM_STATIONS  (NUM_STATIONS),
        .NUM_STREAMS   (NUM_STREAMS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

@@ tb/sv/nearest_time_table_search_top_tb.sv @@
module nearest_time_table_search_top_tb;
    import ntts_pkg::*;

    localparam int          NUM_TABLES  = NUM_STATIONS_DEF * NUM_STREAMS_DEF;
    localparam int          TABLE_DEPTH = TABLE_ENTRIES_DEF;
    localparam logic [63:0] NS_IN_SEC   = 64'd1000000000;
    localparam int          STALL_LIMIT = 5000;
    localparam int          DRAIN_WAIT  = 30;

    typedef logic [31:0] t_sec_list[$];

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_done;
    t_result o_result;

    nearest_time_table_search_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Mirror of the timestamp tables and their fill counts.
    logic [61:0] time_table [NUM_TABLES][TABLE_DEPTH];
    int unsigned table_len [NUM_TABLES];

    t_item   item_q[$];
    t_result answer_q[$];

    logic item_taken = 1'b0;
    int   fail_count = 0;
    int   stall_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    initial forever #6 i_clk = ~i_clk;

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [63:0] to_ns(input logic [61:0] stamp);
        return {32'd0, stamp[61:30]} * NS_IN_SEC + {34'd0, stamp[29:0]};
    endfunction

    function automatic logic [63:0] ns_distance(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Appends or searches exactly as the block should, and queues the answer.
    task automatic table_access(input t_item it);
        t_result     r;
        int unsigned tab, len, lo, hi, mid, pick;
        logic [63:0] q, t, d0, d1;
        r   = '0;
        tab = 32'({it.station_sel, it.stream_sel});
        if (it.operation == OP_LOAD) begin
            if (it.restart) begin
                table_len[tab] = 0;
            end
            len = table_len[tab];
            if (len >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                time_table[tab][len] = {it.entry_seconds, it.entry_nanos};
                table_len[tab]       = len + 1;
                r.status             = ST_OK;
                r.found_index        = 10'(len);
                r.found_seconds      = it.entry_seconds;
                r.found_nanos        = it.entry_nanos;
            end
        end else if (table_len[tab] == 0) begin
            r.status = ST_EMPTY;
        end else begin
            q  = {32'd0, it.query_seconds} * NS_IN_SEC;
            lo = 0;
            hi = table_len[tab] - 1;
            if (to_ns(time_table[tab][lo]) > q) begin
                pick = lo;
            end else if (to_ns(time_table[tab][hi]) < q) begin
                pick = hi;
            end else begin
                // An entry equal to the epoch closes both ends of the bracket.
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    t   = to_ns(time_table[tab][mid]);
                    if (t >= q) hi = mid;
                    if (t <= q) lo = mid;
                end
                d0   = ns_distance(to_ns(time_table[tab][lo]), q);
                d1   = ns_distance(to_ns(time_table[tab][hi]), q);
                pick = (d0 < d1) ? lo : hi;
            end
            r.status        = ST_OK;
            r.found_index   = 10'(pick);
            r.found_seconds = time_table[tab][pick][61:30];
            r.found_nanos   = time_table[tab][pick][29:0];
        end
        answer_q.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_answer(input t_result got);
        t_result want;
        if (answer_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result beat with nothing pending: %p", got);
        end else begin
            want = answer_q.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("found_index", 64'(want.found_index), 64'(got.found_index));
            compare_field("found_seconds", 64'(want.found_seconds), 64'(got.found_seconds));
            compare_field("found_nanos", 64'(want.found_nanos), 64'(got.found_nanos));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (o_done) check_answer(o_result);
            item_taken <= start && !busy;
            if (start && !busy) table_access(i_item);
            if (o_done || (start && !busy)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[nearest_time_table_search_top] ERROR");
                $finish;
            end
        end
    end

    // Items go out in bursts; a beat stays on the port until the block takes it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (start) begin
                void'(item_q.pop_front());
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end else begin
                    burst_left--;
                end
            end
            if (gap_left > 0 || item_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end else begin
                start  <= 1'b1;
                i_item <= item_q[0];
            end
        end
    end

    function automatic t_item load_item(input logic [2:0] tab, input logic rst,
                                        input logic [31:0] sec, input logic [29:0] nanos);
        t_item it;
        it.operation     = OP_LOAD;
        it.station_sel   = tab[2:1];
        it.stream_sel    = tab[0];
        it.restart       = rst;
        it.entry_seconds = sec;
        it.entry_nanos   = nanos;
        it.query_seconds = $urandom;
        return it;
    endfunction

    function automatic t_item query_item(input logic [2:0] tab, input logic [31:0] qsec);
        t_item it;
        it.operation     = OP_QUERY;
        it.station_sel   = tab[2:1];
        it.stream_sel    = tab[0];
        it.restart       = 1'($urandom);
        it.entry_seconds = $urandom;
        it.entry_nanos   = 30'($urandom);
        it.query_seconds = qsec;
        return it;
    endfunction

    function automatic logic [29:0] pick_nanos();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return 30'd500000000;
            3:       return 30'd999999999;
            7:       return 30'($urandom);
            default: return 30'($urandom_range(0, 999999999));
        endcase
    endfunction

    // Epochs mostly land next to loaded seconds so the bisection has work to do.
    function automatic logic [31:0] pick_epoch(input t_sec_list secs);
        int unsigned idx;
        idx = $urandom_range(0, secs.size() - 1);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return secs[0] - 32'd1;
            4:       return secs[secs.size() - 1] + 32'd1;
            default: return secs[idx] + $urandom_range(0, 2) - 32'd1;
        endcase
    endfunction

    initial begin
        t_sec_list   secs;
        logic [31:0] sec;
        logic [2:0]  tab;
        t_item       junk;
        int          n;

        // Empty tables, ties, exact hits, the ends of the range and unsorted loads.
        item_q.push_back(query_item(3'd0, 32'd100));
        item_q.push_back(query_item(3'd7, '1));
        item_q.push_back(load_item(3'd0, 1'b1, 32'd10, 30'd0));
        item_q.push_back(load_item(3'd0, 1'b0, 32'd11, 30'd500000000));
        item_q.push_back(load_item(3'd0, 1'b0, 32'd12, 30'd500000000));
        item_q.push_back(load_item(3'd0, 1'b0, 32'd12, 30'd500000000));
        item_q.push_back(load_item(3'd0, 1'b0, 32'd20, 30'd999999999));
        item_q.push_back(query_item(3'd0, 32'd0));
        item_q.push_back(query_item(3'd0, 32'd10));
        item_q.push_back(query_item(3'd0, 32'd12));
        item_q.push_back(query_item(3'd0, '1));
        item_q.push_back(query_item(3'd0, 32'd15));
        item_q.push_back(load_item(3'd7, 1'b0, '1, '1));
        item_q.push_back(query_item(3'd7, '1));
        item_q.push_back(query_item(3'd7, 32'd0));
        item_q.push_back(load_item(3'd0, 1'b1, 32'd5, '1));
        item_q.push_back(load_item(3'd0, 1'b0, 32'd6, 30'd0));
        item_q.push_back(query_item(3'd0, 32'd6));
        item_q.push_back(load_item(3'd2, 1'b1, 32'd0, 30'd0));
        item_q.push_back(query_item(3'd2, 32'd0));
        item_q.push_back(load_item(3'd5, 1'b1, 32'd100, 30'd1000000000));
        item_q.push_back(load_item(3'd5, 1'b0, 32'd101, 30'd0));
        item_q.push_back(query_item(3'd5, 32'd101));

        // Fill one table to the brim, overflow it, then search the full depth.
        tab = 3'd3;
        sec = 32'd1000;
        for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
            item_q.push_back(load_item(tab, i == 0, sec, pick_nanos()));
            if (i < TABLE_DEPTH) secs.push_back(sec);
            sec += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        end
        for (int i = 0; i < 40; i++) item_q.push_back(query_item(tab, pick_epoch(secs)));

        // Mostly restart-then-append runs followed by searches, some raw noise.
        while (item_q.size() < 2100) begin
            if ($urandom_range(0, 9) == 0) begin
                junk.operation     = 1'($urandom);
                junk.station_sel   = 2'($urandom);
                junk.stream_sel    = 1'($urandom);
                junk.restart       = 1'($urandom);
                junk.entry_seconds = $urandom;
                junk.entry_nanos   = 30'($urandom);
                junk.query_seconds = $urandom;
                item_q.push_back(junk);
            end else begin
                tab = 3'($urandom);
                secs.delete();
                sec = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
                n   = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    item_q.push_back(load_item(tab, i == 0 && $urandom_range(0, 5) != 0,
                                               sec, pick_nanos()));
                    secs.push_back(sec);
                    sec += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                end
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) item_q.push_back(query_item(tab, pick_epoch(secs)));
            end
        end

        do @(posedge i_clk); while (item_q.size() != 0 || answer_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[nearest_time_table_search_top] OK");
        end else begin
            $display("[nearest_time_table_search_top] ERROR");
        end
        $finish;
    end

endmodule
